### rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// Soft particle pair force package
// Shared register indexes, pipeline sizes and the sideband records that
// travel with each particle pair through the arithmetic units.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Configuration port index width and register indexes.
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_WIDTH   = 4'd0,
    REG_BOX_HEIGHT  = 4'd1,
    REG_PERIODIC    = 4'd2,
    REG_FADE_AGE    = 4'd3,
    REG_CUTOFF      = 4'd4,
    REG_BOUNDARY    = 4'd5,
    REG_STIFFNESS   = 4'd6,
    REG_ATTRACTION  = 4'd7
  } cfg_reg_e;

  // Number of register stages in each iterative unit.
  localparam int unsigned FadeSteps = 16;  // quotient bits of the fade factor
  localparam int unsigned RootSteps = 31;  // root bits of a 62-bit radicand
  localparam int unsigned QuotSteps = 35;  // quotient bits of the projection

  // Live configuration register values.
  typedef struct packed {
    logic [30:0] box_width;
    logic [30:0] box_height;
    logic        periodic_mode;
    logic [31:0] fade_age;
    logic [15:0] contact_cutoff;
    logic        boundary_type;
    logic [63:0] stiffness_table;
    logic [63:0] attraction_table;
  } cfg_t;

  // Pair data after the front stage (wrapped geometry and thresholds).
  typedef struct packed {
    logic        far;
    logic        sx;
    logic        sy;
    logic [29:0] ax;
    logic [29:0] ay;
    logic [24:0] b;
    logic [25:0] t1;
    logic [26:0] t2;
    logic [28:0] tc;
    logic [15:0] k;
    logic        fade_en;
  } front_t;

  // Pair data carried through the square root.
  typedef struct packed {
    logic        far;
    logic        sx;
    logic        sy;
    logic [26:0] ax;
    logic [26:0] ay;
    logic [24:0] b;
    logic [25:0] t1;
    logic [26:0] t2;
    logic [28:0] tc;
    logic [15:0] k;
    logic        fade_en;
    logic [16:0] fi;
    logic [16:0] fj;
  } mid_t;

  // Pair data carried through the projection divider and the fade stages.
  typedef struct packed {
    logic        cneg;
    logic        contact;
    logic        sx;
    logic        sy;
    logic        fade_en;
    logic [16:0] fi;
    logic [16:0] fj;
  } back_t;

endpackage

### rtl/soft_particle_pair_force_unit.sv
// ----------------------------------------------------------------------------
// Soft particle pair force unit
// Usage: each input transfer carries one particle pair (positions, radii,
// types, ages); each output transfer carries the force on particle i and
// its contact flag. Exactly one result leaves for every pair, in order.
// The configuration channel writes the box, fade, contact and table
// registers; write it only while no pair is in flight.
// Pipeline: 92 register stages. The square root (31 stages), the projection
// divider (35 stages) and the fade divider (16 stages) each resolve one bit
// per stage and make up most of these stages.
// Throughput: one pair per cycle when the receiver keeps out_ready_i high.
// Reset: all valid bits clear, so the pipeline is empty; the configuration
// registers return to their reset values and the block takes pairs at once.
// Stall: while a result waits and out_ready_i is low, the whole pipeline
// holds and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module soft_particle_pair_force_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 pos_x_i_i,
  input  logic [31:0]                 pos_y_i_i,
  input  logic [31:0]                 pos_x_j_i,
  input  logic [31:0]                 pos_y_j_i,
  input  logic [15:0]                 radius_i_i,
  input  logic [15:0]                 radius_j_i,
  input  logic                        kind_i_i,
  input  logic                        kind_j_i,
  input  logic [31:0]                 age_i_i,
  input  logic [31:0]                 age_j_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 force_x_o,
  output logic [31:0]                 force_y_o,
  output logic                        in_contact_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);
  import spf_pkg::*;

  cfg_t cfg;
  logic en;

  // Minimum-image wrap of one displacement axis.
  function automatic logic signed [34:0] wrap_axis(logic signed [32:0] r,
                                                   logic [30:0] len,
                                                   logic per);
    logic signed [34:0] r35;
    logic signed [34:0] l35;
    logic signed [34:0] two;
    r35 = {{2{r[32]}}, r};
    l35 = {4'b0000, len};
    two = r35 <<< 1;
    if (per && (two > l35)) begin
      r35 = r35 - l35;
    end else if (per && (two < -l35)) begin
      r35 = r35 + l35;
    end
    return r35;
  endfunction

  // Saturate a signed magnitude to 32 bits.
  function automatic logic [31:0] sat_out(logic [34:0] mag, logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (mag > 35'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end else begin
      r = (mag >= 35'h080000000) ? 32'h80000000 : 32'(-mag);
    end
    return r;
  endfunction

  spf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The whole pipeline moves together unless a result waits untaken.
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- stage 1
  // Displacement, wrap, magnitudes, thresholds and table lookup.
  front_t             s1_d;
  front_t             s1_q;
  logic               s1_vld_q;
  logic [31:0]        s1_age_i_q;
  logic [31:0]        s1_age_j_q;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [34:0] wx;
  logic signed [34:0] wy;
  logic [33:0]        absx;
  logic [33:0]        absy;
  logic [16:0]        bq;
  logic [1:0]         tsel;
  logic [15:0]        eps;
  logic [16:0]        e1;
  logic [17:0]        e2;
  logic [33:0]        p1;
  logic [34:0]        p2;
  logic [32:0]        pc;

  always_comb begin
    dx   = $signed({pos_x_j_i[31], pos_x_j_i}) - $signed({pos_x_i_i[31], pos_x_i_i});
    dy   = $signed({pos_y_j_i[31], pos_y_j_i}) - $signed({pos_y_i_i[31], pos_y_i_i});
    wx   = wrap_axis(dx, cfg.box_width, cfg.periodic_mode);
    wy   = wrap_axis(dy, cfg.box_height, cfg.periodic_mode);
    absx = wx[34] ? 34'(-wx) : wx[33:0];
    absy = wy[34] ? 34'(-wy) : wy[33:0];
    bq   = {1'b0, radius_i_i} + {1'b0, radius_j_i};
    tsel = {kind_i_i, kind_j_i};
    eps  = cfg.attraction_table[{tsel, 4'b0000} +: 16];
    e1   = {1'b0, eps} + 17'h10000;
    e2   = {1'b0, eps, 1'b0} + 18'h10000;
    p1   = 34'(bq) * 34'(e1);
    p2   = 35'(bq) * 35'(e2);
    pc   = 33'(bq) * 33'(cfg.contact_cutoff);

    s1_d.far     = (absx[33:30] != 4'd0) || (absy[33:30] != 4'd0);
    s1_d.sx      = wx[34];
    s1_d.sy      = wy[34];
    s1_d.ax      = absx[29:0];
    s1_d.ay      = absy[29:0];
    s1_d.b       = {bq, 8'h00};
    s1_d.t1      = p1[33:8];
    s1_d.t2      = p2[34:8];
    s1_d.tc      = pc[32:4];
    s1_d.k       = cfg.stiffness_table[{tsel, 4'b0000} +: 16];
    s1_d.fade_en = (kind_j_i != cfg.boundary_type);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q       <= s1_d;
      s1_age_i_q <= age_i_i;
      s1_age_j_q <= age_j_i;
    end
  end

  // ------------------------------------------------------------ fade factors
  logic        fd_vld;
  logic [16:0] fd_fi;
  logic [16:0] fd_fj;
  front_t      fd_side;

  spf_fade u_fade (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s1_vld_q),
    .age_a_i   (s1_age_i_q),
    .age_b_i   (s1_age_j_q),
    .fade_age_i(cfg.fade_age),
    .side_i    (s1_q),
    .valid_o   (fd_vld),
    .fi_o      (fd_fi),
    .fj_o      (fd_fj),
    .side_o    (fd_side)
  );

  // ---------------------------------------------------------------- stage 2
  // Squares of the axis magnitudes.
  mid_t        s2_d;
  mid_t        s2_q;
  logic        s2_vld_q;
  logic [59:0] s2_sqx_q;
  logic [59:0] s2_sqy_q;

  always_comb begin
    s2_d.far     = fd_side.far;
    s2_d.sx      = fd_side.sx;
    s2_d.sy      = fd_side.sy;
    s2_d.ax      = fd_side.ax[26:0];
    s2_d.ay      = fd_side.ay[26:0];
    s2_d.b       = fd_side.b;
    s2_d.t1      = fd_side.t1;
    s2_d.t2      = fd_side.t2;
    s2_d.tc      = fd_side.tc;
    s2_d.k       = fd_side.k;
    s2_d.fade_en = fd_side.fade_en;
    s2_d.fi      = fd_fi;
    s2_d.fj      = fd_fj;
  end

  // ---------------------------------------------------------------- stage 3
  // Sum of squares feeds the root.
  mid_t        s3_q;
  logic        s3_vld_q;
  logic [61:0] s3_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= fd_vld;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s2_d;
      s2_sqx_q <= 60'(fd_side.ax) * 60'(fd_side.ax);
      s2_sqy_q <= 60'(fd_side.ay) * 60'(fd_side.ay);
      s3_q     <= s2_q;
      s3_rad_q <= 62'(s2_sqx_q) + 62'(s2_sqy_q);
    end
  end

  // ------------------------------------------------------------ square root
  logic        rt_vld;
  logic [30:0] rt_d;
  mid_t        rt_side;

  spf_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_vld_q),
    .rad_i  (s3_rad_q),
    .side_i (s3_q),
    .valid_o(rt_vld),
    .root_o (rt_d),
    .side_o (rt_side)
  );

  // ---------------------------------------------------------------- stage 4
  // Force region, spring extension and contact test.
  back_t       s4_d;
  back_t       s4_q;
  logic        s4_vld_q;
  logic [26:0] s4_cmag_d;
  logic [26:0] s4_cmag_q;
  logic [15:0] s4_k_q;
  logic [26:0] s4_div_d;
  logic [26:0] s4_div_q;
  logic [26:0] s4_ax_q;
  logic [26:0] s4_ay_q;
  logic        s4_act;
  logic        lt1;
  logic        lt2;
  logic        ltb;
  logic [30:0] cdiff;

  always_comb begin
    lt1    = rt_d < 31'(rt_side.t1);
    lt2    = rt_d < 31'(rt_side.t2);
    ltb    = rt_d < 31'(rt_side.b);
    s4_act = !rt_side.far && (rt_d != '0) && lt2;
    if (lt1) begin
      cdiff = ltb ? (31'(rt_side.b) - rt_d) : (rt_d - 31'(rt_side.b));
    end else begin
      cdiff = 31'(rt_side.t2) - rt_d;
    end
    s4_cmag_d    = s4_act ? cdiff[26:0] : '0;
    s4_div_d     = s4_act ? rt_d[26:0] : 27'd1;
    s4_d.cneg    = lt1 && ltb;
    s4_d.contact = !rt_side.far && (rt_d < 31'(rt_side.tc));
    s4_d.sx      = rt_side.sx;
    s4_d.sy      = rt_side.sy;
    s4_d.fade_en = rt_side.fade_en;
    s4_d.fi      = rt_side.fi;
    s4_d.fj      = rt_side.fj;
  end

  // ------------------------------------------------------- stages 5 to 7
  // Spring force magnitude, split projection products and their sum.
  logic        s5_vld_q;
  back_t       s5_q;
  logic [34:0] s5_m_q;
  logic [26:0] s5_div_q;
  logic [26:0] s5_ax_q;
  logic [26:0] s5_ay_q;
  logic [42:0] kprod;

  logic        s6_vld_q;
  back_t       s6_q;
  logic [26:0] s6_div_q;
  logic [44:0] s6_xl_q;
  logic [43:0] s6_xh_q;
  logic [44:0] s6_yl_q;
  logic [43:0] s6_yh_q;

  logic        s7_vld_q;
  back_t       s7_q;
  logic [26:0] s7_div_q;
  logic [61:0] s7_nx_q;
  logic [61:0] s7_ny_q;

  assign kprod = 43'(s4_k_q) * 43'(s4_cmag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= rt_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q      <= s4_d;
      s4_cmag_q <= s4_cmag_d;
      s4_k_q    <= rt_side.k;
      s4_div_q  <= s4_div_d;
      s4_ax_q   <= s4_act ? rt_side.ax : '0;
      s4_ay_q   <= s4_act ? rt_side.ay : '0;

      s5_q      <= s4_q;
      s5_m_q    <= kprod[42:8];
      s5_div_q  <= s4_div_q;
      s5_ax_q   <= s4_ax_q;
      s5_ay_q   <= s4_ay_q;

      s6_q      <= s5_q;
      s6_div_q  <= s5_div_q;
      s6_xl_q   <= 45'(s5_m_q[17:0]) * 45'(s5_ax_q);
      s6_xh_q   <= 44'(s5_m_q[34:18]) * 44'(s5_ax_q);
      s6_yl_q   <= 45'(s5_m_q[17:0]) * 45'(s5_ay_q);
      s6_yh_q   <= 44'(s5_m_q[34:18]) * 44'(s5_ay_q);

      s7_q      <= s6_q;
      s7_div_q  <= s6_div_q;
      s7_nx_q   <= (62'(s6_xh_q) << 18) + 62'(s6_xl_q);
      s7_ny_q   <= (62'(s6_yh_q) << 18) + 62'(s6_yl_q);
    end
  end

  // ------------------------------------------------------ projection divider
  logic        qt_vld;
  logic [34:0] qt_x;
  logic [34:0] qt_y;
  back_t       qt_side;

  spf_quot u_quot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s7_vld_q),
    .num_x_i(s7_nx_q),
    .num_y_i(s7_ny_q),
    .div_i  (s7_div_q),
    .side_i (s7_q),
    .valid_o(qt_vld),
    .quo_x_o(qt_x),
    .quo_y_o(qt_y),
    .side_o (qt_side)
  );

  // ------------------------------------------------------- stages 8 and 9
  // Fade scaling by particle i, then by particle j, when fade_en is set.
  logic        s8_vld_q;
  back_t       s8_q;
  logic [34:0] s8_x_q;
  logic [34:0] s8_y_q;
  logic [51:0] fx_i;
  logic [51:0] fy_i;

  logic        s9_vld_q;
  back_t       s9_q;
  logic [34:0] s9_x_q;
  logic [34:0] s9_y_q;
  logic [51:0] fx_j;
  logic [51:0] fy_j;

  assign fx_i = 52'(qt_x) * 52'(qt_side.fi);
  assign fy_i = 52'(qt_y) * 52'(qt_side.fi);
  assign fx_j = 52'(s8_x_q) * 52'(s8_q.fj);
  assign fy_j = 52'(s8_y_q) * 52'(s8_q.fj);

  // ---------------------------------------------------------------- output
  logic [31:0] force_x_q;
  logic [31:0] force_y_q;
  logic        contact_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q  <= qt_vld;
      s9_vld_q  <= s8_vld_q;
      out_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q      <= qt_side;
      s8_x_q    <= qt_side.fade_en ? fx_i[50:16] : qt_x;
      s8_y_q    <= qt_side.fade_en ? fy_i[50:16] : qt_y;
      s9_q      <= s8_q;
      s9_x_q    <= s8_q.fade_en ? fx_j[50:16] : s8_x_q;
      s9_y_q    <= s8_q.fade_en ? fy_j[50:16] : s8_y_q;
      force_x_q <= sat_out(s9_x_q, s9_q.cneg != s9_q.sx);
      force_y_q <= sat_out(s9_y_q, s9_q.cneg != s9_q.sy);
      contact_q <= s9_q.contact;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign force_x_o    = force_x_q;
  assign force_y_o    = force_y_q;
  assign in_contact_o = contact_q;

endmodule

### rtl/spf_cfg.sv
// ----------------------------------------------------------------------------
// Soft particle pair force configuration registers
// Holds the box, fade, contact and type-pair table registers written
// through the configuration channel.
// ----------------------------------------------------------------------------
module spf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  output spf_pkg::cfg_t               cfg_o
);
  import spf_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file update on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_width        <= '0;
      cfg_q.box_height       <= '0;
      cfg_q.periodic_mode    <= 1'b0;
      cfg_q.fade_age         <= '0;
      cfg_q.contact_cutoff   <= 16'd4096;
      cfg_q.boundary_type    <= 1'b1;
      cfg_q.stiffness_table  <= '0;
      cfg_q.attraction_table <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_WIDTH:  cfg_q.box_width        <= cfg_data_i[30:0];
        REG_BOX_HEIGHT: cfg_q.box_height       <= cfg_data_i[30:0];
        REG_PERIODIC:   cfg_q.periodic_mode    <= cfg_data_i[0];
        REG_FADE_AGE:   cfg_q.fade_age         <= cfg_data_i[31:0];
        REG_CUTOFF:     cfg_q.contact_cutoff   <= cfg_data_i[15:0];
        REG_BOUNDARY:   cfg_q.boundary_type    <= cfg_data_i[0];
        REG_STIFFNESS:  cfg_q.stiffness_table  <= cfg_data_i;
        REG_ATTRACTION: cfg_q.attraction_table <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### rtl/spf_fade.sv
// ----------------------------------------------------------------------------
// Soft particle pair force fade-in divider
// Pipelined restoring divider that forms (age << 16) / fade_age for both
// particles, one quotient bit per stage, or 1.0 once the age is reached.
// ----------------------------------------------------------------------------
module spf_fade (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     age_a_i,
  input  logic [31:0]     age_b_i,
  input  logic [31:0]     fade_age_i,
  input  spf_pkg::front_t side_i,
  output logic            valid_o,
  output logic [16:0]     fi_o,
  output logic [16:0]     fj_o,
  output spf_pkg::front_t side_o
);
  import spf_pkg::*;

  typedef struct packed {
    logic        lt;
    logic [31:0] rem;
    logic [15:0] q;
  } fade_lane_t;

  fade_lane_t             la_q [FadeSteps];
  fade_lane_t             lb_q [FadeSteps];
  fade_lane_t             la_d [FadeSteps];
  fade_lane_t             lb_d [FadeSteps];
  front_t                 side_q [FadeSteps];
  logic [FadeSteps-1:0]   vld_q;
  fade_lane_t             init_a;
  fade_lane_t             init_b;

  // One restoring step: shift in a zero numerator bit and try to subtract.
  function automatic fade_lane_t fade_step(fade_lane_t x, logic [31:0] dv);
    fade_lane_t r;
    logic [32:0] t;
    logic        bit_q;
    t     = {x.rem, 1'b0};
    bit_q = (t >= {1'b0, dv});
    r.lt  = x.lt;
    r.rem = bit_q ? 32'(t - {1'b0, dv}) : t[31:0];
    r.q   = {x.q[14:0], bit_q};
    return r;
  endfunction

  // A young particle starts with its age as the partial remainder.
  always_comb begin
    init_a.lt  = (age_a_i < fade_age_i);
    init_a.rem = init_a.lt ? age_a_i : '0;
    init_a.q   = '0;
    init_b.lt  = (age_b_i < fade_age_i);
    init_b.rem = init_b.lt ? age_b_i : '0;
    init_b.q   = '0;
  end

  for (genvar s = 0; s < FadeSteps; s++) begin : g_step
    if (s == 0) begin : g_first
      always_comb begin
        la_d[s] = fade_step(init_a, fade_age_i);
        lb_d[s] = fade_step(init_b, fade_age_i);
      end
    end else begin : g_next
      always_comb begin
        la_d[s] = fade_step(la_q[s-1], fade_age_i);
        lb_d[s] = fade_step(lb_q[s-1], fade_age_i);
      end
    end
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FadeSteps-2:0], valid_i};
    end
  end

  // Lane and sideband registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la_q      <= la_d;
      lb_q      <= lb_d;
      side_q[0] <= side_i;
      for (int s = 1; s < FadeSteps; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[FadeSteps-1];
  assign side_o  = side_q[FadeSteps-1];
  assign fi_o    = la_q[FadeSteps-1].lt ? {1'b0, la_q[FadeSteps-1].q} : 17'h10000;
  assign fj_o    = lb_q[FadeSteps-1].lt ? {1'b0, lb_q[FadeSteps-1].q} : 17'h10000;

endmodule

### rtl/spf_root.sv
// ----------------------------------------------------------------------------
// Soft particle pair force square root
// Pipelined digit-by-digit integer square root of a 62-bit radicand, one
// root bit per stage, with the pair sideband carried alongside.
// ----------------------------------------------------------------------------
module spf_root (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [61:0]   rad_i,
  input  spf_pkg::mid_t side_i,
  output logic          valid_o,
  output logic [30:0]   root_o,
  output spf_pkg::mid_t side_o
);
  import spf_pkg::*;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
  } root_lane_t;

  root_lane_t           lane_q [RootSteps];
  root_lane_t           lane_d [RootSteps];
  mid_t                 side_q [RootSteps];
  logic [RootSteps-1:0] vld_q;
  root_lane_t           lane_init;

  // Bring down the next two radicand bits and try the next root bit.
  function automatic root_lane_t root_step(root_lane_t x);
    root_lane_t  r;
    logic [34:0] t;
    logic [34:0] trial;
    t     = {x.rem, x.rad[61:60]};
    trial = {2'b00, x.root, 2'b01};
    r.rad = {x.rad[59:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 33'(t - trial);
      r.root = {x.root[29:0], 1'b1};
    end else begin
      r.rem  = t[32:0];
      r.root = {x.root[29:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    lane_init.rem  = '0;
    lane_init.root = '0;
    lane_init.rad  = rad_i;
  end

  for (genvar s = 0; s < RootSteps; s++) begin : g_step
    if (s == 0) begin : g_first
      always_comb lane_d[s] = root_step(lane_init);
    end else begin : g_next
      always_comb lane_d[s] = root_step(lane_q[s-1]);
    end
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootSteps-2:0], valid_i};
    end
  end

  // Lane and sideband registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q    <= lane_d;
      side_q[0] <= side_i;
      for (int s = 1; s < RootSteps; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[RootSteps-1];
  assign root_o  = lane_q[RootSteps-1].root;
  assign side_o  = side_q[RootSteps-1];

endmodule

### rtl/spf_quot.sv
// ----------------------------------------------------------------------------
// Soft particle pair force projection divider
// Pipelined restoring divider that forms both force components m*|r|/d,
// one quotient bit per stage, sharing the distance as divisor.
// ----------------------------------------------------------------------------
module spf_quot (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [61:0]    num_x_i,
  input  logic [61:0]    num_y_i,
  input  logic [26:0]    div_i,
  input  spf_pkg::back_t side_i,
  output logic           valid_o,
  output logic [34:0]    quo_x_o,
  output logic [34:0]    quo_y_o,
  output spf_pkg::back_t side_o
);
  import spf_pkg::*;

  typedef struct packed {
    logic [26:0] rem;
    logic [34:0] num;
    logic [34:0] q;
  } quot_lane_t;

  quot_lane_t           lx_q [QuotSteps];
  quot_lane_t           ly_q [QuotSteps];
  quot_lane_t           lx_d [QuotSteps];
  quot_lane_t           ly_d [QuotSteps];
  logic [26:0]          div_q [QuotSteps];
  back_t                side_q [QuotSteps];
  logic [QuotSteps-1:0] vld_q;
  quot_lane_t           init_x;
  quot_lane_t           init_y;

  // Shift in the next numerator bit and try to subtract the divisor.
  function automatic quot_lane_t quot_step(quot_lane_t x, logic [26:0] dv);
    quot_lane_t  r;
    logic [27:0] t;
    logic        bit_q;
    t     = {x.rem, x.num[34]};
    bit_q = (t >= {1'b0, dv});
    r.rem = bit_q ? 27'(t - {1'b0, dv}) : t[26:0];
    r.num = {x.num[33:0], 1'b0};
    r.q   = {x.q[33:0], bit_q};
    return r;
  endfunction

  // The quotient fits 35 bits, so the upper numerator bits start below d.
  always_comb begin
    init_x.rem = num_x_i[61:35];
    init_x.num = num_x_i[34:0];
    init_x.q   = '0;
    init_y.rem = num_y_i[61:35];
    init_y.num = num_y_i[34:0];
    init_y.q   = '0;
  end

  for (genvar s = 0; s < QuotSteps; s++) begin : g_step
    if (s == 0) begin : g_first
      always_comb begin
        lx_d[s] = quot_step(init_x, div_i);
        ly_d[s] = quot_step(init_y, div_i);
      end
    end else begin : g_next
      always_comb begin
        lx_d[s] = quot_step(lx_q[s-1], div_q[s-1]);
        ly_d[s] = quot_step(ly_q[s-1], div_q[s-1]);
      end
    end
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotSteps-2:0], valid_i};
    end
  end

  // Lane, divisor and sideband registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q      <= lx_d;
      ly_q      <= ly_d;
      div_q[0]  <= div_i;
      side_q[0] <= side_i;
      for (int s = 1; s < QuotSteps; s++) begin
        div_q[s]  <= div_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[QuotSteps-1];
  assign quo_x_o = lx_q[QuotSteps-1].q;
  assign quo_y_o = ly_q[QuotSteps-1].q;
  assign side_o  = side_q[QuotSteps-1];

endmodule
